/* sv/srsg_pkg.sv */
// shared constants, types and the sequencer program of the step generator
package srsg_pkg;

    localparam int unsigned TICKS_PER_SECOND = 1000000;
    localparam int unsigned POSITION_BITS    = 32;

    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned ACC_W     = 37;
    localparam int unsigned SPD_W     = 21;
    localparam int unsigned MAG_W     = SPD_W;
    localparam int unsigned ACCEL_W   = 24;
    localparam int unsigned PW_W      = 8;
    localparam int unsigned IV_W      = 20;
    localparam int unsigned IO_POS_W  = 32;
    localparam int unsigned TPS_W     = $clog2(TICKS_PER_SECOND + 1);
    localparam int unsigned APB_AW    = 3;
    localparam int unsigned APB_DW    = 32;

    localparam logic [IV_W-1:0]  IV_MAX   = '1;
    localparam logic [PW_W-1:0]  PW_RESET = PW_W'(60);
    localparam logic [TPS_W-1:0] TPS_VAL  = TPS_W'(TICKS_PER_SECOND);

    // register select, taken from paddr[2]
    localparam logic REG_ACCEL = 1'b0;
    localparam logic REG_PULSE = 1'b1;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_TICK,
        OP_DIFF,
        OP_RAMP,
        OP_MAG,
        OP_DIV_START,
        OP_INTV,
        OP_STEP
    } t_op;

    typedef enum logic [2:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_INPUT,
        C_DIV_BUSY,
        C_OUT_BUSY,
        C_MAG_ZERO
    } t_cond;

    localparam int unsigned UC_DEPTH = 8;
    localparam int unsigned PC_W     = $clog2(UC_DEPTH);
    typedef logic [PC_W-1:0] t_pc;

    localparam t_pc PC_FETCH   = PC_W'(0);
    localparam t_pc PC_DIFF    = PC_W'(1);
    localparam t_pc PC_RAMP    = PC_W'(2);
    localparam t_pc PC_MAG     = PC_W'(3);
    localparam t_pc PC_DIVGO   = PC_W'(4);
    localparam t_pc PC_DIVWAIT = PC_W'(5);
    localparam t_pc PC_INTV    = PC_W'(6);
    localparam t_pc PC_DECIDE  = PC_W'(7);

    // hold: stay on this step while true; jump: taken to target after the step runs
    typedef struct packed {
        t_op   op;
        t_cond hold;
        t_cond jump;
        t_pc   target;
    } t_uword;

    localparam t_uword UCODE [UC_DEPTH] = '{
        '{OP_TICK,      C_NO_INPUT, C_NEVER,    PC_FETCH},
        '{OP_DIFF,      C_NEVER,    C_NEVER,    PC_FETCH},
        '{OP_RAMP,      C_NEVER,    C_NEVER,    PC_FETCH},
        '{OP_MAG,       C_NEVER,    C_NEVER,    PC_FETCH},
        '{OP_DIV_START, C_NEVER,    C_MAG_ZERO, PC_INTV},
        '{OP_NOP,       C_DIV_BUSY, C_NEVER,    PC_FETCH},
        '{OP_INTV,      C_NEVER,    C_NEVER,    PC_FETCH},
        '{OP_STEP,      C_OUT_BUSY, C_ALWAYS,   PC_FETCH}
    };

    typedef struct packed {
        logic             busy;
        logic [TPS_W-1:0] quot;
    } t_div_stat;

endpackage

/* sv/srsg_if.sv */
// word channels of the step generator: tick input and per-tick result
interface srsg_in_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [srsg_pkg::IO_POS_W-1:0]  target_position;
    logic signed [srsg_pkg::SPD_W-1:0]     goal_speed;
    logic                                  load_position;
    logic signed [srsg_pkg::IO_POS_W-1:0]  new_position;

    modport source (output valid, target_position, goal_speed, load_position, new_position,
                    input ready);
    modport sink   (input valid, target_position, goal_speed, load_position, new_position,
                    output ready);
endinterface

interface srsg_out_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  step_level;
    logic                                  dir_level;
    logic                                  stepped;
    logic signed [srsg_pkg::IO_POS_W-1:0]  current_position;
    logic signed [srsg_pkg::SPD_W-1:0]     current_speed;

    modport source (output valid, step_level, dir_level, stepped, current_position,
                    current_speed, input ready);
    modport sink   (input valid, step_level, dir_level, stepped, current_position,
                    current_speed, output ready);
endinterface

/* sv/srsg_div.sv */
// iterative restoring divider: ticks per second over speed magnitude, one bit a cycle
module srsg_div (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  logic [srsg_pkg::MAG_W-1:0]   i_divisor,
    output srsg_pkg::t_div_stat          o_stat
);
    import srsg_pkg::*;

    localparam int unsigned CNT_W = $clog2(TPS_W + 1);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [MAG_W-1:0] r_rem;
    logic [MAG_W-1:0] r_dvs;
    logic [TPS_W-1:0] r_dvd;
    logic [TPS_W-1:0] r_quot;

    logic [MAG_W:0]   w_trial;
    logic             w_ge;
    logic [MAG_W:0]   w_diff;

    assign w_trial = {r_rem, r_dvd[TPS_W-1]};
    assign w_ge    = w_trial >= {1'b0, r_dvs};
    assign w_diff  = w_trial - {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNT_W'(TPS_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - 1'b1;
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= '0;
            r_dvs  <= i_divisor;
            r_dvd  <= TPS_VAL;
            r_quot <= '0;
        end else if (r_busy) begin
            r_rem  <= w_ge ? w_diff[MAG_W-1:0] : w_trial[MAG_W-1:0];
            r_dvd  <= {r_dvd[TPS_W-2:0], 1'b0};
            r_quot <= {r_quot[TPS_W-2:0], w_ge};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.quot = r_quot;

endmodule

/* sv/stepper_ramp_step_generator.sv */
// top level of the stepper step generator with a signed linear speed ramp
//
// usage
//   i_in carries one word per timer tick: target position, goal speed and an
//   optional position load. o_out returns one word per tick: step pin level,
//   direction pin level, a stepped flag, the position and the whole-step speed.
//   both channels use valid/ready; a word moves when both are high.
//   accel_per_tick (addr 0) and pulse_width (addr 4) sit on the apb port; the user
//   must write them only while no tick is in flight, which the block does not enforce.
// timing
//   a small microcoded sequencer walks up to eight steps per tick: fetch, ramp
//   difference, ramp update, magnitude, divider start, divider wait, interval,
//   step decision; the divider wait is skipped when the speed is zero. the
//   divider retires one quotient bit per cycle. a new tick is taken only once
//   the sequencer is back at fetch, after the step decision of the last one.
// reset
//   i_rst_n is synchronous, active low: speed, interval, counters and position
//   clear, direction goes clockwise, accel 0, pulse width 60.
// stall
//   the result sits in an output register; the next tick is accepted and
//   worked on while it waits, and the sequencer holds on the step decision
//   only if the previous word has still not been taken.
module stepper_ramp_step_generator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    srsg_in_if.sink                       i_in,
    srsg_out_if.source                    o_out,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [srsg_pkg::APB_AW-1:0]   paddr,
    input  logic [srsg_pkg::APB_DW-1:0]   pwdata,
    output logic [srsg_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);
    import srsg_pkg::*;

    localparam int unsigned POS_W = POSITION_BITS;

    // config registers
    logic [ACCEL_W-1:0] r_accel;
    logic [PW_W-1:0]    r_pw;

    // sequencer
    t_pc    r_pc;
    t_pc    n_pc;
    t_uword w_uw;
    logic   w_hold;
    logic   w_jump;
    logic   w_go;

    // tick state
    logic signed [ACC_W-1:0] r_speed;
    logic [IV_W-1:0]         r_interval;
    logic [IV_W-1:0]         r_since;
    logic [POS_W-1:0]        r_pos;
    logic                    r_dir;
    logic [PW_W-1:0]         r_pulse;

    // per-tick working registers
    logic [POS_W-1:0]        r_target;
    logic signed [SPD_W-1:0] r_goal;
    logic                    r_pin_high;
    logic signed [ACC_W:0]   r_diff;
    logic [MAG_W-1:0]        r_mag;
    logic                    r_neg;
    logic [SPD_W-1:0]        r_speed_whole;

    // output register
    logic                    r_out_valid;
    logic                    r_out_step;
    logic                    r_out_dir;
    logic                    r_out_stepped;
    logic [IO_POS_W-1:0]     r_out_pos;
    logic [SPD_W-1:0]        r_out_speed;

    // divider
    logic      w_div_start;
    t_div_stat w_div;

    // datapath helpers
    logic signed [ACC_W:0]   w_goal_x;
    logic signed [ACC_W:0]   w_accel_x;
    logic signed [ACC_W:0]   w_sum;
    logic                    w_snap;
    logic [ACC_W-1:0]        w_abs;
    logic [IV_W-1:0]         w_iv;
    logic                    w_step;
    logic [PW_W-1:0]         w_pw_eff;
    logic [PW_W-1:0]         w_pulse_next;
    logic [POS_W-1:0]        w_pos_next;
    logic                    w_out_busy;
    logic                    w_cfg_wr;

    function automatic logic cond_true(input t_cond c, input logic no_input,
                                       input logic div_busy, input logic out_busy,
                                       input logic mag_zero);
        logic r;
        case (c)
            C_NEVER:    r = 1'b0;
            C_ALWAYS:   r = 1'b1;
            C_NO_INPUT: r = no_input;
            C_DIV_BUSY: r = div_busy;
            C_OUT_BUSY: r = out_busy;
            C_MAG_ZERO: r = mag_zero;
            default:    r = 1'b0;
        endcase
        return r;
    endfunction

    // ---------------- configuration port ----------------
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite;
    assign prdata   = (paddr[2] == REG_PULSE) ? APB_DW'(r_pw) : APB_DW'(r_accel);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel <= '0;
            r_pw    <= PW_RESET;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_PULSE) begin
                r_pw <= pwdata[PW_W-1:0];
            end else begin
                r_accel <= pwdata[ACCEL_W-1:0];
            end
        end
    end

    // ---------------- sequencer ----------------
    assign w_uw       = UCODE[r_pc];
    assign w_out_busy = r_out_valid && !o_out.ready;
    assign w_hold     = cond_true(w_uw.hold, !i_in.valid, w_div.busy, w_out_busy, r_mag == '0);
    assign w_jump     = cond_true(w_uw.jump, !i_in.valid, w_div.busy, w_out_busy, r_mag == '0);
    assign w_go       = !w_hold;

    always_comb begin
        if (w_hold) begin
            n_pc = r_pc;
        end else if (w_jump) begin
            n_pc = w_uw.target;
        end else begin
            n_pc = r_pc + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= PC_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

    assign i_in.ready = (r_pc == PC_FETCH);

    // ---------------- datapath ----------------
    // goal speed in q21.16, one guard bit for the difference
    assign w_goal_x  = {{(ACC_W + 1 - SPD_W - FRAC_BITS){r_goal[SPD_W-1]}}, r_goal,
                        {FRAC_BITS{1'b0}}};
    assign w_accel_x = $signed({{(ACC_W + 1 - ACCEL_W){1'b0}}, r_accel});
    assign w_sum     = r_diff + w_accel_x;
    // within one increment of the goal: |diff| <= accel
    assign w_snap    = r_diff[ACC_W] ? !w_sum[ACC_W] : (r_diff <= w_accel_x);
    assign w_abs     = r_speed[ACC_W-1] ? ACC_W'(-r_speed) : ACC_W'(r_speed);

    // interval clamp: at least one tick, at most the counter range
    always_comb begin
        if (64'(w_div.quot) > 64'(IV_MAX)) begin
            w_iv = IV_MAX;
        end else if (w_div.quot == '0) begin
            w_iv = IV_W'(1);
        end else begin
            w_iv = IV_W'(w_div.quot);
        end
    end

    assign w_div_start = w_go && (w_uw.op == OP_DIV_START) && (r_mag != '0);

    srsg_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_divisor (r_mag),
        .o_stat    (w_div)
    );

    // step decision: interval elapsed, pin low at tick start, not at target
    assign w_step       = (r_interval != '0) && (r_since >= r_interval) && !r_pin_high &&
                          (r_pos != r_target);
    assign w_pw_eff     = (r_pw != '0) ? r_pw : PW_W'(1);
    assign w_pulse_next = w_step ? w_pw_eff : r_pulse;
    assign w_pos_next   = !w_step ? r_pos : (r_dir ? r_pos + 1'b1 : r_pos - 1'b1);

    // tick state, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed    <= '0;
            r_interval <= '0;
            r_since    <= '0;
            r_pos      <= '0;
            r_dir      <= 1'b1;
            r_pulse    <= '0;
        end else if (w_go) begin
            case (w_uw.op)
                OP_TICK: begin
                    if (r_pulse != '0) begin
                        r_pulse <= r_pulse - 1'b1;
                    end
                    if (r_since != IV_MAX) begin
                        r_since <= r_since + 1'b1;
                    end
                    if (i_in.load_position) begin
                        r_pos <= POS_W'(i_in.new_position);
                    end
                end
                OP_RAMP: begin
                    if (w_snap) begin
                        r_speed <= ACC_W'(w_goal_x);
                    end else if (!r_diff[ACC_W]) begin
                        r_speed <= r_speed + ACC_W'(w_accel_x);
                    end else begin
                        r_speed <= r_speed - ACC_W'(w_accel_x);
                    end
                end
                OP_INTV: begin
                    if (r_mag == '0) begin
                        r_interval <= '0;
                    end else begin
                        r_interval <= w_iv;
                        r_dir      <= !r_neg;
                    end
                end
                OP_STEP: begin
                    r_pos   <= w_pos_next;
                    r_pulse <= w_pulse_next;
                    if (w_step) begin
                        r_since <= '0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // per-tick working values
    always_ff @(posedge i_clk) begin
        if (w_go) begin
            case (w_uw.op)
                OP_TICK: begin
                    r_pin_high <= (r_pulse != '0);
                    r_target   <= POS_W'(i_in.target_position);
                    r_goal     <= i_in.goal_speed;
                end
                OP_DIFF: begin
                    r_diff <= w_goal_x - (ACC_W + 1)'(r_speed);
                end
                OP_MAG: begin
                    r_mag <= w_abs[ACC_W-1:FRAC_BITS];
                    r_neg <= r_speed[ACC_W-1];
                end
                OP_INTV: begin
                    r_speed_whole <= r_neg ? SPD_W'(-r_mag) : SPD_W'(r_mag);
                end
                default: begin
                end
            endcase
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_go && (w_uw.op == OP_STEP)) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_go && (w_uw.op == OP_STEP)) begin
            r_out_step    <= (w_pulse_next != '0);
            r_out_dir     <= r_dir;
            r_out_stepped <= w_step;
            r_out_pos     <= IO_POS_W'(w_pos_next);
            r_out_speed   <= r_speed_whole;
        end
    end

    assign o_out.valid            = r_out_valid;
    assign o_out.step_level       = r_out_step;
    assign o_out.dir_level        = r_out_dir;
    assign o_out.stepped          = r_out_stepped;
    assign o_out.current_position = r_out_pos;
    assign o_out.current_speed    = r_out_speed;

    // ---------------- assertions ----------------
    // a step always raises the pin, pulse width is at least one tick
    a_step_pin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.stepped) |-> o_out.step_level)
        else $error("step issued without step pin high");

    // the divider only runs while the sequencer waits for it
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.busy |-> (r_pc == PC_DIVWAIT))
        else $error("divider busy outside the wait step");

    // stepping is disabled exactly when the whole-step speed is zero
    a_iv_mag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == PC_DECIDE) |-> ((r_interval == '0) == (r_mag == '0)))
        else $error("interval and speed magnitude disagree");

    // a step moves the position by exactly one
    a_pos_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_go && (w_uw.op == OP_STEP) && w_step) |=>
        ((r_pos == $past(r_pos) + 1'b1) || (r_pos == $past(r_pos) - 1'b1)))
        else $error("step did not move position by one");

endmodule

/* sim/stepper_ramp_step_generator_tb.sv */
// testbench of the stepper ramp step generator: tick stimulus, tick-level predictor, scoreboard
module stepper_ramp_step_generator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import srsg_pkg::*;

    localparam int unsigned CYCLE_LIMIT   = 2_000_000;
    localparam int unsigned SETTLE_CYCLES = 60;
    localparam int unsigned ACCEL_MAX     = 24'hFF_FFFF;
    localparam int          GOAL_MAX      = 1048575;
    localparam int          GOAL_MIN      = -1048576;
    localparam int unsigned REPORT_LIMIT  = 10;

    // one tick word as the sender offers it
    typedef struct {
        logic signed [IO_POS_W-1:0] target;
        logic signed [SPD_W-1:0]    goal;
        logic                       load;
        logic signed [IO_POS_W-1:0] new_position;
    } t_tick_word;

    // one result word as the block returns it
    typedef struct {
        logic                       step_level;
        logic                       dir_level;
        logic                       stepped;
        logic signed [IO_POS_W-1:0] position;
        logic signed [SPD_W-1:0]    speed;
    } t_tick_result;

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [APB_AW-1:0]   paddr;
    logic [APB_DW-1:0]   pwdata;
    logic [APB_DW-1:0]   prdata;
    logic                pready;

    srsg_in_if  tick_in ();
    srsg_out_if tick_out ();

    stepper_ramp_step_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (tick_in),
        .o_out   (tick_out),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 i_clk = ~i_clk;

    // traffic shaping, percent of cycles spent idle or stalled
    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;

    t_tick_word   pending_ticks[$];
    t_tick_result expected_results[$];
    t_tick_word   on_wire;

    int unsigned cycle_count = 0;
    int unsigned mismatch_count = 0;
    int unsigned result_count = 0;

    // predictor state, reset values as the block comes out of reset
    int unsigned              m_accel = 0;
    int unsigned              m_pulse_width = 60;
    longint                   m_speed_acc = 0;
    int unsigned              m_interval = 0;
    int unsigned              m_since_step = 0;
    logic [POSITION_BITS-1:0] m_position = '0;
    bit                       m_dir = 1'b1;
    int unsigned              m_pulse_timer = 0;

    // advance the predictor by one tick and return the word it should produce
    function automatic t_tick_result advance_tick(t_tick_word w);
        logic [POSITION_BITS-1:0] aim;
        longint                   goal_acc;
        longint                   gap;
        longint                   gap_abs;
        longint unsigned          mag;
        longint unsigned          quot;
        longint                   speed_whole;
        bit                       pin_was_high;
        t_tick_result             r;

        aim = POSITION_BITS'(w.target);
        r.stepped = 1'b0;

        // timers first: pulse counts down, time since last step counts up
        pin_was_high = (m_pulse_timer != 0);
        if (m_pulse_timer != 0)
            m_pulse_timer--;
        if (m_since_step < IV_MAX)
            m_since_step++;

        if (w.load)
            m_position = POSITION_BITS'(w.new_position);

        // signed ramp toward the goal, snapping when within one increment
        goal_acc = longint'(w.goal) <<< FRAC_BITS;
        if (m_speed_acc != goal_acc) begin
            gap = goal_acc - m_speed_acc;
            gap_abs = (gap < 0) ? -gap : gap;
            if (gap_abs <= longint'(m_accel))
                m_speed_acc = goal_acc;
            else if (gap > 0)
                m_speed_acc += longint'(m_accel);
            else
                m_speed_acc -= longint'(m_accel);
        end

        // whole-step magnitude sets the interval; zero speed disables stepping
        mag = ((m_speed_acc < 0) ? -m_speed_acc : m_speed_acc) >> FRAC_BITS;
        if (mag == 0) begin
            m_interval = 0;
        end else begin
            quot = TICKS_PER_SECOND / mag;
            if (quot > IV_MAX)
                quot = IV_MAX;
            if (quot == 0)
                quot = 1;
            m_interval = int'(quot);
            m_dir = (m_speed_acc > 0);
        end
        speed_whole = (m_speed_acc < 0) ? -longint'(mag) : longint'(mag);

        // no step while the pin was high at the start of the tick
        if (m_interval != 0 && m_since_step >= m_interval && !pin_was_high &&
            m_position != aim) begin
            m_position = m_dir ? m_position + 1'b1 : m_position - 1'b1;
            m_since_step = 0;
            m_pulse_timer = (m_pulse_width != 0) ? m_pulse_width : 1;
            r.stepped = 1'b1;
        end

        r.step_level = (m_pulse_timer != 0);
        r.dir_level = m_dir;
        r.position = IO_POS_W'(m_position);
        r.speed = SPD_W'(speed_whole);
        return r;
    endfunction

    // sender: holds a word until taken, predicts it at acceptance
    always @(posedge i_clk) begin : tick_driver
        if (!i_rst_n) begin
            tick_in.valid <= 1'b0;
        end else begin
            if (tick_in.valid && tick_in.ready)
                expected_results.push_back(advance_tick(on_wire));
            if (!tick_in.valid || tick_in.ready) begin
                if (pending_ticks.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    on_wire = pending_ticks.pop_front();
                    tick_in.valid <= 1'b1;
                    tick_in.target_position <= on_wire.target;
                    tick_in.goal_speed <= on_wire.goal;
                    tick_in.load_position <= on_wire.load;
                    tick_in.new_position <= on_wire.new_position;
                end else begin
                    tick_in.valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string name, logic signed [63:0] want, logic signed [63:0] got);
        if (got !== want) begin
            if (mismatch_count < REPORT_LIMIT)
                $display("result %0d %s: expected %0d, got %0d", result_count, name, want, got);
            mismatch_count++;
        end
    endtask

    // receiver: compares each taken word with the oldest prediction
    always @(posedge i_clk) begin : result_monitor
        t_tick_result want;
        if (!i_rst_n) begin
            tick_out.ready <= 1'b0;
        end else begin
            if (tick_out.valid && tick_out.ready) begin
                if (expected_results.size() == 0) begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("result %0d arrived with no tick pending", result_count);
                    mismatch_count++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("step_level", want.step_level, tick_out.step_level);
                    check_field("dir_level", want.dir_level, tick_out.dir_level);
                    check_field("stepped", want.stepped, tick_out.stepped);
                    check_field("current_position", want.position, tick_out.current_position);
                    check_field("current_speed", want.speed, tick_out.current_speed);
                end
                result_count++;
            end
            tick_out.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // apb write: setup cycle, then access cycle; the register takes it at the end of the access cycle
    task automatic write_reg(logic sel, logic [APB_DW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {sel, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (sel == REG_ACCEL)
            m_accel = value[ACCEL_W-1:0];
        else
            m_pulse_width = value[PW_W-1:0];
    endtask

    function automatic void add_tick(int aim, int goal, logic load, int new_pos);
        t_tick_word w;
        w.target = IO_POS_W'(aim);
        w.goal = SPD_W'(goal);
        w.load = load;
        w.new_position = IO_POS_W'(new_pos);
        pending_ticks.push_back(w);
    endfunction

    // mostly short moves: load a position, then aim a few steps off it for a while;
    // the rest random targets, stray loads and rare goals off the ramp
    task automatic queue_ticks(int unsigned count, int goal_lo, int goal_hi);
        t_tick_word          w;
        int unsigned         hold_left;
        logic [IO_POS_W-1:0] aim;
        hold_left = 0;
        aim = '0;
        repeat (count) begin
            if ($urandom_range(31) == 0)
                w.goal = SPD_W'($urandom);
            else
                w.goal = SPD_W'(goal_lo + int'($urandom_range(goal_hi - goal_lo)));
            w.load = 1'b0;
            w.new_position = $urandom;
            if (hold_left == 0 && $urandom_range(23) == 0) begin
                // some moves start around the wrap point
                if ($urandom_range(2) == 0)
                    w.new_position = 32'h7FFF_FFF8 + $urandom_range(15);
                w.load = 1'b1;
                aim = w.new_position + $urandom_range(16) - 8;
                hold_left = $urandom_range(48, 4);
            end else if ($urandom_range(63) == 0) begin
                w.load = 1'b1;
            end
            if (hold_left != 0) begin
                w.target = aim;
                hold_left--;
            end else begin
                w.target = $urandom;
            end
            pending_ticks.push_back(w);
        end
    endtask

    // block is idle once everything queued has gone through and come back
    task automatic wait_idle();
        while (pending_ticks.size() != 0 || tick_in.valid || expected_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        tick_in.valid = 1'b0;
        tick_in.target_position = '0;
        tick_in.goal_speed = '0;
        tick_in.load_position = 1'b0;
        tick_in.new_position = '0;
        tick_out.ready = 1'b0;

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset settings: zero acceleration keeps the speed at zero; load extremes
        add_tick(0, GOAL_MAX, 1'b0, 0);
        add_tick(32'h7FFF_FFFF, GOAL_MIN, 1'b1, 32'h8000_0000);
        add_tick(32'h8000_0000, -1, 1'b1, 32'h7FFF_FFFF);
        add_tick(0, 0, 1'b1, 0);
        wait_idle();

        // full acceleration, zero pulse width
        write_reg(REG_ACCEL, ACCEL_MAX);
        write_reg(REG_PULSE, 0);
        add_tick(100, -1, 1'b0, 0);          // direction goes counterclockwise
        add_tick(100, 0, 1'b0, 0);           // zero speed holds the direction
        add_tick(100, 1, 1'b0, 0);
        add_tick(100, 0, 1'b0, 0);
        add_tick(-100, GOAL_MAX, 1'b0, 0);
        add_tick(-100, GOAL_MIN, 1'b0, 0);
        add_tick(-100, GOAL_MIN, 1'b0, 0);
        add_tick(-100, 0, 1'b0, 0);          // snaps to exactly zero from one increment below
        add_tick(-100, 0, 1'b0, 0);
        wait_idle();

        // smallest acceleration: fractional speeds only
        write_reg(REG_ACCEL, 1);
        write_reg(REG_PULSE, 255);
        add_tick(5, 1, 1'b0, 0);
        add_tick(5, 1, 1'b0, 0);
        add_tick(5, -1, 1'b1, 32'h5555_5555);
        add_tick(5, -1, 1'b0, 32'hAAAA_AAAA);
        wait_idle();

        // ramp up toward the top at full acceleration
        write_reg(REG_ACCEL, ACCEL_MAX);
        write_reg(REG_PULSE, 1);
        queue_ticks(30, GOAL_MAX - 1000, GOAL_MAX);
        wait_idle();

        // random or extreme settings and high goals under each traffic pattern
        for (int mode = 0; mode < 4; mode++) begin
            case (mode)
                0: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                    write_reg(REG_ACCEL, $urandom_range(ACCEL_MAX));
                    write_reg(REG_PULSE, 1);
                end
                1: begin
                    send_idle_pct = 64;
                    recv_stall_pct = 0;
                    write_reg(REG_ACCEL, ACCEL_MAX);
                    write_reg(REG_PULSE, 0);
                end
                2: begin
                    send_idle_pct = 0;
                    recv_stall_pct = 64;
                    write_reg(REG_ACCEL, $urandom_range(4095));
                    write_reg(REG_PULSE, $urandom_range(8, 2));
                end
                default: begin
                    send_idle_pct = 20;
                    recv_stall_pct = 20;
                    write_reg(REG_ACCEL, $urandom_range(ACCEL_MAX));
                    write_reg(REG_PULSE, 255);
                end
            endcase
            queue_ticks(80, 900000, GOAL_MAX);
            wait_idle();
        end

        // ramp down toward the counterclockwise limit
        send_idle_pct = 0;
        recv_stall_pct = 0;
        write_reg(REG_ACCEL, ACCEL_MAX);
        write_reg(REG_PULSE, 2);
        queue_ticks(30, GOAL_MIN, GOAL_MIN + 1000);
        wait_idle();

        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
